>>> hdl/mailbox_address_translation_table_top_macros.svh
// assertion helpers for the address translation table
`ifndef MAILBOX_ADDRESS_TRANSLATION_TABLE_TOP_MACROS_SVH
`define MAILBOX_ADDRESS_TRANSLATION_TABLE_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define MATT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define MATT_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`else

`define MATT_ASSERT(label, prop, msg)

`define MATT_ASSERT_NEVER(label, cond, msg)

`endif

`endif

>>> hdl/matt_pkg.sv
`timescale 1ns / 1ps

package matt_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	localparam int ADDR_W = 32;
	localparam int PHYS_W = 33;
	localparam int OFFSET_W = 12;
	localparam logic [ADDR_W-1:0] PAGE_MASK = 32'hFFFF_F000;

	typedef enum logic [1:0] {
		OP_SET_PENDING = 2'd0,
		OP_MAP         = 2'd1,
		OP_UNMAP       = 2'd2,
		OP_TRANSLATE   = 2'd3
	} opcode_t;

	typedef enum logic [3:0] {
		ST_IDLE    = 4'b0001,
		ST_SCAN    = 4'b0010,
		ST_MOVE_RD = 4'b0100,
		ST_MOVE_WR = 4'b1000
	} state_t;

endpackage

>>> hdl/mailbox_address_translation_table_top.sv
// Fully associative I/O address translation table driven by mailbox words.
// Input channel: opcode and value are taken at a clock edge where start is
// high and busy is low. Result channel: phys_addr and hit are valid for the
// single cycle in which strobe is high; the receiver cannot stall it.
// Opcode set-pending latches value as the pending key; busy stays low.
// Map, unmap and translate scan the stored entries in slot order through
// one read port and one key comparator, one entry per cycle. After a hit,
// unmap reads the last entry and moves it into the freed slot. Translate
// gives exactly one result word; strobe rises together with busy falling.
// The other opcodes give no result word. Reset empties the table and
// clears the pending key; the entry storage itself is not cleared, since
// only slots below the fill count are ever read.
`timescale 1ns / 1ps
`include "mailbox_address_translation_table_top_macros.svh"

module mailbox_address_translation_table_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 opcode,
	input  logic [matt_pkg::ADDR_W-1:0] value,
	output logic                       strobe,
	output logic [matt_pkg::PHYS_W-1:0] phys_addr,
	output logic                       hit
);

	matt_pkg::state_t state_q;
	logic [1:0] op_q;
	logic [matt_pkg::ADDR_W-1:0] val_q;
	logic [matt_pkg::ADDR_W-1:0] key_q;
	logic [matt_pkg::ADDR_W-1:0] pending_q;
	logic [matt_pkg::CNT_W-1:0] count_q;
	logic [matt_pkg::CNT_W-1:0] scan_idx_q;
	logic [matt_pkg::IDX_W-1:0] rd_idx_q;
	logic [matt_pkg::IDX_W-1:0] match_idx_q;
	logic rd_vld_q;
	logic strobe_q;
	logic hit_q;
	logic [matt_pkg::PHYS_W-1:0] phys_q;

	logic [matt_pkg::ADDR_W-1:0] key_mem [matt_pkg::TABLE_ENTRIES];
	logic [matt_pkg::ADDR_W-1:0] tgt_mem [matt_pkg::TABLE_ENTRIES];
	logic [matt_pkg::ADDR_W-1:0] key_rd_q;
	logic [matt_pkg::ADDR_W-1:0] tgt_rd_q;

	logic accept;
	logic issue;
	logic match;
	logic rd_en;
	logic [matt_pkg::IDX_W-1:0] rd_addr;
	logic wr_en;
	logic [matt_pkg::IDX_W-1:0] wr_addr;
	logic [matt_pkg::ADDR_W-1:0] wr_key;
	logic [matt_pkg::ADDR_W-1:0] wr_tgt;
	logic [matt_pkg::CNT_W-1:0] last_idx;
	logic table_full;
	logic [matt_pkg::PHYS_W-1:0] hit_sum;

	assign busy = (state_q != matt_pkg::ST_IDLE);
	assign accept = start && !busy;
	assign strobe = strobe_q;
	assign phys_addr = phys_q;
	assign hit = hit_q;

	assign issue = (state_q == matt_pkg::ST_SCAN) && (scan_idx_q < count_q);
	assign match = rd_vld_q && (key_rd_q == key_q);
	assign last_idx = count_q - matt_pkg::CNT_W'(1);
	assign table_full = (count_q >= matt_pkg::CNT_W'(matt_pkg::TABLE_ENTRIES));
	assign hit_sum = {1'b0, tgt_rd_q} +
		matt_pkg::PHYS_W'(val_q[matt_pkg::OFFSET_W-1:0]);

	// memory port control
	always_comb begin
		rd_en = 1'b0;
		rd_addr = scan_idx_q[matt_pkg::IDX_W-1:0];
		wr_en = 1'b0;
		wr_addr = rd_idx_q;
		wr_key = key_q;
		wr_tgt = val_q;
		case (state_q)
			matt_pkg::ST_SCAN: begin
				rd_en = issue;
				if (op_q == matt_pkg::OP_MAP) begin
					if (match) begin
						wr_en = 1'b1;
						wr_addr = rd_idx_q;
					end else if (!issue && !table_full) begin
						wr_en = 1'b1;
						wr_addr = count_q[matt_pkg::IDX_W-1:0];
					end
				end
			end
			matt_pkg::ST_MOVE_RD: begin
				rd_en = 1'b1;
				rd_addr = last_idx[matt_pkg::IDX_W-1:0];
			end
			matt_pkg::ST_MOVE_WR: begin
				wr_en = 1'b1;
				wr_addr = match_idx_q;
				wr_key = key_rd_q;
				wr_tgt = tgt_rd_q;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			key_rd_q <= key_mem[rd_addr];
			tgt_rd_q <= tgt_mem[rd_addr];
		end
		if (wr_en) begin
			key_mem[wr_addr] <= wr_key;
			tgt_mem[wr_addr] <= wr_tgt;
		end
	end

	// operand capture, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= opcode;
			val_q <= value;
			case (opcode)
				matt_pkg::OP_MAP:       key_q <= pending_q;
				matt_pkg::OP_TRANSLATE: key_q <= value & matt_pkg::PAGE_MASK;
				default:                key_q <= value;
			endcase
		end
		if (issue) begin
			rd_idx_q <= scan_idx_q[matt_pkg::IDX_W-1:0];
		end
		if (state_q == matt_pkg::ST_SCAN && match) begin
			match_idx_q <= rd_idx_q;
		end
		if (state_q == matt_pkg::ST_SCAN && (match || !issue)) begin
			hit_q <= match;
			phys_q <= match ? hit_sum : {1'b0, val_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= matt_pkg::ST_IDLE;
			pending_q <= '0;
			count_q <= '0;
			scan_idx_q <= '0;
			rd_vld_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			rd_vld_q <= issue;
			case (state_q)
				matt_pkg::ST_IDLE: begin
					scan_idx_q <= '0;
					rd_vld_q <= 1'b0;
					if (accept) begin
						if (opcode == matt_pkg::OP_SET_PENDING) begin
							pending_q <= value;
						end else begin
							state_q <= matt_pkg::ST_SCAN;
						end
					end
				end
				matt_pkg::ST_SCAN: begin
					if (issue) begin
						scan_idx_q <= scan_idx_q + matt_pkg::CNT_W'(1);
					end
					// first matching slot ends the scan, else running out of slots
					if (match || !issue) begin
						state_q <= matt_pkg::ST_IDLE;
						case (op_q)
							matt_pkg::OP_TRANSLATE: begin
								strobe_q <= 1'b1;
							end
							matt_pkg::OP_MAP: begin
								if (!match && !table_full) begin
									count_q <= count_q + matt_pkg::CNT_W'(1);
								end
							end
							matt_pkg::OP_UNMAP: begin
								if (match) begin
									state_q <= matt_pkg::ST_MOVE_RD;
								end
							end
							default: begin
								state_q <= matt_pkg::ST_IDLE;
							end
						endcase
					end
				end
				matt_pkg::ST_MOVE_RD: begin
					state_q <= matt_pkg::ST_MOVE_WR;
				end
				matt_pkg::ST_MOVE_WR: begin
					count_q <= last_idx;
					state_q <= matt_pkg::ST_IDLE;
				end
				default: begin
					state_q <= matt_pkg::ST_IDLE;
				end
			endcase
		end
	end

	`MATT_ASSERT_NEVER(a_count_range, count_q > matt_pkg::CNT_W'(matt_pkg::TABLE_ENTRIES), "fill count beyond table size")
	`MATT_ASSERT(a_strobe_single, strobe_q |=> !strobe_q, "result word strobe held two cycles")
	`MATT_ASSERT(a_strobe_from_scan, strobe_q |-> $past(state_q == matt_pkg::ST_SCAN), "result word without a scan")
	`MATT_ASSERT(a_strobe_translate, strobe_q |-> (op_q == matt_pkg::OP_TRANSLATE), "result word for a non-translate op")
	`MATT_ASSERT(a_move_order, (state_q == matt_pkg::ST_MOVE_WR) |-> $past(state_q == matt_pkg::ST_MOVE_RD), "entry move write without read")

endmodule
